// File: rtl/delimiter_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// delimiter_tokenizer_defines.svh
// Assertion macros for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef DELIMITER_TOKENIZER_DEFINES_SVH
`define DELIMITER_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DTOK_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DTOK_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dtok_pkg.sv
// ----------------------------------------------------------------------------
// dtok_pkg
// Types, constants and helpers shared by the delimiter tokenizer.
// ----------------------------------------------------------------------------
package dtok_pkg;

  localparam int DELIM_MAX = 8;
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = $clog2(DELIM_MAX + 1);
  localparam int IDX_W     = 3;

  // configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_DELIM_BYTES = 3'd0,
    REG_DELIM_COUNT = 3'd1,
    REG_WHOLE_MODE  = 3'd2,
    REG_DROP_EMPTY  = 3'd3,
    REG_ESCAPE_BYTE = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              byte_present;
    logic              string_end;
  } item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              out_byte_valid;
    logic              token_done;
    logic              string_done;
    logic              run_last;
  } result_t;

  typedef struct packed {
    logic [DELIM_MAX*BYTE_W-1:0] delim_bytes;
    logic [3:0]                  delim_count;
    logic                        whole_mode;
    logic                        drop_empty;
    logic [BYTE_W-1:0]           escape_byte;
  } cfg_t;

  // per-cell compare flags against each delimiter position
  typedef logic [DELIM_MAX-1:0] eq_row_t;
  typedef eq_row_t [DELIM_MAX-1:0] eq_grid_t;

  // tokenizer state seen by the planner
  typedef struct packed {
    logic [CNT_W-1:0] held;
    logic             tok_ne;
    logic             esc_pend;
  } tok_state_t;

  // work plan of one accepted transaction
  typedef struct packed {
    logic [CNT_W-1:0] rem;
    logic [1:0]       ctrl;
    logic             bare;
    logic [CNT_W-1:0] held;
    logic             tok_ne;
    logic             esc_pend;
  } plan_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // delimiter count as used: zero acts as one, large values saturate
  function automatic logic [CNT_W-1:0] clamp_count(input logic [3:0] raw);
    logic [CNT_W-1:0] c;
    c = CNT_W'(raw);
    if (raw == 4'd0) begin
      c = CNT_W'(1);
    end else if (raw > 4'(DELIM_MAX)) begin
      c = CNT_W'(DELIM_MAX);
    end
    return c;
  endfunction

endpackage

// File: rtl/dtok_cell.sv
// ----------------------------------------------------------------------------
// dtok_cell
// One window cell: holds a byte, shifts from its right neighbor and
// compares its byte against every delimiter byte.
// ----------------------------------------------------------------------------
module dtok_cell (
  input  logic                                       clk,
  input  dtok_pkg::cell_ctrl_t                       ctrl,
  input  logic [dtok_pkg::BYTE_W-1:0]                load_byte,
  input  logic [dtok_pkg::BYTE_W-1:0]                next_byte,
  input  logic [dtok_pkg::DELIM_MAX*dtok_pkg::BYTE_W-1:0] delim_bytes,
  output logic [dtok_pkg::BYTE_W-1:0]                cell_byte,
  output dtok_pkg::eq_row_t                          eq
);
  import dtok_pkg::*;

  // byte storage: a load wins over the shift from the neighbor
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      cell_byte <= load_byte;
    end else if (ctrl.shift) begin
      cell_byte <= next_byte;
    end
  end

  // compare against each delimiter position
  always_comb begin
    for (int t = 0; t < DELIM_MAX; t++) begin
      eq[t] = (cell_byte == delim_bytes[BYTE_W*t +: BYTE_W]);
    end
  end

endmodule

// File: rtl/dtok_plan.sv
// ----------------------------------------------------------------------------
// dtok_plan
// Works out, for one transaction, how many window bytes go out, which
// token marks follow and the tokenizer state left behind.
// ----------------------------------------------------------------------------
module dtok_plan (
  input  dtok_pkg::cfg_t       cfg,
  input  dtok_pkg::item_t      item,
  input  dtok_pkg::tok_state_t st,
  input  dtok_pkg::eq_grid_t   view_eq,
  output dtok_pkg::plan_t      plan
);
  import dtok_pkg::*;

  logic [CNT_W-1:0]     c;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     js;
  eq_row_t              b_eq;
  eq_row_t              cnt_mask;
  eq_grid_t             em;
  logic [DELIM_MAX-1:0] diag;
  logic [DELIM_MAX-1:0] cond;
  logic                 match;
  logic                 is_delim;
  logic                 is_esc;
  logic                 tok1;
  logic                 tokl;
  logic [CNT_W-1:0]     r1;
  logic [CNT_W-1:0]     r;
  logic [CNT_W-1:0]     kept;
  logic                 tok;
  logic                 esc;
  logic                 t1;
  logic                 t2;
  logic                 bare;

  // compare matrix of the window with the new byte appended
  always_comb begin
    c = clamp_count(cfg.delim_count);
    n = st.held + CNT_W'(1);
    for (int t = 0; t < DELIM_MAX; t++) begin
      b_eq[t]     = (item.in_byte == cfg.delim_bytes[BYTE_W*t +: BYTE_W]);
      cnt_mask[t] = (CNT_W'(t) < c);
    end
    for (int p = 0; p < DELIM_MAX; p++) begin
      for (int t = 0; t < DELIM_MAX; t++) begin
        if (CNT_W'(p) < st.held) begin
          em[p][t] = view_eq[p][t];
        end else if (CNT_W'(p) == st.held) begin
          em[p][t] = b_eq[t];
        end else begin
          em[p][t] = 1'b1;
        end
      end
    end
  end

  // every alignment in parallel: does the tail from j on start the delimiter
  always_comb begin
    for (int j = 0; j < DELIM_MAX; j++) begin
      diag[j] = 1'b1;
      for (int t = 0; t < DELIM_MAX; t++) begin
        if (j + t < DELIM_MAX) begin
          if (CNT_W'(j + t) < n) begin
            diag[j] = diag[j] & em[j+t][t];
          end
        end
      end
      cond[j] = diag[j] && (CNT_W'(j) < n) && ((n - CNT_W'(j)) <= c);
    end
    js = n;
    for (int j = DELIM_MAX - 1; j >= 0; j--) begin
      if (cond[j]) begin
        js = CNT_W'(j);
      end
    end
    match = ((n - js) == c);
  end

  // any-of byte classes
  assign is_delim = |(b_eq & cnt_mask);
  assign is_esc   = (cfg.escape_byte != '0) && (item.in_byte == cfg.escape_byte);

  // per-transaction plan
  always_comb begin
    r1   = '0;
    kept = st.held;
    tok  = st.tok_ne;
    esc  = st.esc_pend;
    t1   = 1'b0;
    tok1 = st.tok_ne || (st.held != '0);
    if (item.byte_present) begin
      if (cfg.whole_mode) begin
        esc = 1'b0;
        r1  = js;
        if (match) begin
          t1   = st.tok_ne || (js != '0) || !cfg.drop_empty;
          tok  = 1'b0;
          kept = '0;
        end else begin
          tok  = st.tok_ne || (js != '0);
          kept = n - js;
        end
      end else begin
        kept = '0;
        r1   = st.held;
        if (st.esc_pend) begin
          r1  = n;
          esc = 1'b0;
          tok = 1'b1;
        end else if (is_esc) begin
          r1  = n;
          esc = 1'b1;
          tok = 1'b1;
        end else if (is_delim) begin
          t1  = tok1 || !cfg.drop_empty;
          tok = 1'b0;
        end else begin
          r1  = n;
          tok = 1'b1;
        end
      end
    end
    r    = r1;
    t2   = 1'b0;
    bare = 1'b0;
    tokl = tok || (kept != '0);
    if (item.string_end) begin
      r    = r1 + kept;
      t2   = tokl || !cfg.drop_empty;
      bare = (r == '0) && !t1 && !t2;
      kept = '0;
      tok  = 1'b0;
      esc  = 1'b0;
    end
    plan.rem      = r;
    plan.ctrl     = {1'b0, t1} + {1'b0, t2} + {1'b0, bare};
    plan.bare     = bare;
    plan.held     = r + kept;
    plan.tok_ne   = tok;
    plan.esc_pend = esc;
  end

endmodule

// File: rtl/delimiter_tokenizer.sv
// ----------------------------------------------------------------------------
// delimiter_tokenizer
// Splits a byte stream into tokens in any-of or whole-string mode.
// ----------------------------------------------------------------------------
// Bytes that may start a delimiter sit in a row of eight window cells; each
// cell compares its byte against all delimiter bytes so a whole-string match
// is decided in the cycle a byte arrives. Results leave one per cycle, while
// result_stall is low, from a registered output, window bytes shifting out
// of the row's head. A transaction that yields at most one result leaves the
// input free, so one byte per cycle streams through while the output is not
// stalled; a transaction that yields k results (at most nine, at token ends
// or string ends) stalls the input while the cell row drains. Configuration
// is taken in any cycle and has no effect on work in progress only if written
// while idle. No clearing pass follows reset.
`include "delimiter_tokenizer_defines.svh"

module delimiter_tokenizer (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  dtok_pkg::item_t          item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output dtok_pkg::result_t        result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [dtok_pkg::IDX_W-1:0] cfg_index,
  input  logic [dtok_pkg::DELIM_MAX*dtok_pkg::BYTE_W-1:0] cfg_data
);
  import dtok_pkg::*;

  cfg_t                            cfg;
  logic [CNT_W-1:0]                held;
  logic [CNT_W-1:0]                rem;
  logic [1:0]                      ctrl_cnt;
  logic                            ctrl_bare;
  logic                            str_end;
  logic                            tok_ne;
  logic                            esc_pend;

  logic [CNT_W-1:0]                held_next;
  logic [CNT_W-1:0]                rem_next;
  logic [1:0]                      ctrl_next;
  logic [CNT_W:0]                  work_cnt;
  logic                            adv;
  logic                            issue;
  logic                            shift;
  logic                            accept;
  logic                            free;
  result_t                         res_next;
  tok_state_t                      view_st;
  plan_t                           plan;
  eq_grid_t                        view_eq;
  logic [DELIM_MAX:0][BYTE_W-1:0]  chain;
  eq_row_t [DELIM_MAX:0]           eq;
  cell_ctrl_t [DELIM_MAX-1:0]      cell_ctrl;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.delim_bytes <= '0;
      cfg.delim_count <= 4'd1;
      cfg.whole_mode  <= 1'b1;
      cfg.drop_empty  <= 1'b0;
      cfg.escape_byte <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DELIM_BYTES: cfg.delim_bytes <= cfg_data;
        REG_DELIM_COUNT: cfg.delim_count <= cfg_data[3:0];
        REG_WHOLE_MODE:  cfg.whole_mode  <= cfg_data[0];
        REG_DROP_EMPTY:  cfg.drop_empty  <= cfg_data[0];
        REG_ESCAPE_BYTE: cfg.escape_byte <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // issue control: one result per cycle whenever the output register frees
  assign work_cnt = {1'b0, rem} + (CNT_W+1)'(ctrl_cnt);
  assign adv      = !result_valid || !result_stall;
  assign issue    = adv && (work_cnt != '0);
  assign shift    = issue && (rem != '0);

  always_comb begin
    held_next = held - CNT_W'(shift);
    rem_next  = rem - CNT_W'(shift);
    ctrl_next = ctrl_cnt - 2'((issue && (rem == '0)) ? 1 : 0);
  end

  // a new transaction enters once nothing is left after this cycle
  assign free       = (rem_next == '0) && (ctrl_next == '0);
  assign item_stall = !free;
  assign accept     = item_valid && free;

  // window cell row
  assign chain[DELIM_MAX] = '0;
  assign eq[DELIM_MAX]    = '0;

  for (genvar i = 0; i < DELIM_MAX; i++) begin : g_cell
    assign cell_ctrl[i].load  = accept && item.byte_present && (held_next == CNT_W'(i));
    assign cell_ctrl[i].shift = shift;

    dtok_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .load_byte   (item.in_byte),
      .next_byte   (chain[i+1]),
      .delim_bytes (cfg.delim_bytes),
      .cell_byte   (chain[i]),
      .eq          (eq[i])
    );

    // compare flags as the row will stand after this cycle's shift
    assign view_eq[i] = shift ? eq[i+1] : eq[i];
  end

  // planner sees the state left by this cycle's issue
  assign view_st.held     = held_next;
  assign view_st.tok_ne   = tok_ne;
  assign view_st.esc_pend = esc_pend;

  dtok_plan u_plan (
    .cfg     (cfg),
    .item    (item),
    .st      (view_st),
    .view_eq (view_eq),
    .plan    (plan)
  );

  // work counters and token state
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      rem       <= '0;
      ctrl_cnt  <= '0;
      ctrl_bare <= 1'b0;
      str_end   <= 1'b0;
      tok_ne    <= 1'b0;
      esc_pend  <= 1'b0;
    end else if (accept) begin
      held      <= plan.held;
      rem       <= plan.rem;
      ctrl_cnt  <= plan.ctrl;
      ctrl_bare <= plan.bare;
      str_end   <= item.string_end;
      tok_ne    <= plan.tok_ne;
      esc_pend  <= plan.esc_pend;
    end else begin
      held      <= held_next;
      rem       <= rem_next;
      ctrl_cnt  <= ctrl_next;
    end
  end

  // result of this cycle: window bytes first, then token marks
  always_comb begin
    if (rem != '0) begin
      res_next.out_byte       = chain[0];
      res_next.out_byte_valid = 1'b1;
      res_next.token_done     = 1'b0;
    end else begin
      res_next.out_byte       = '0;
      res_next.out_byte_valid = 1'b0;
      res_next.token_done     = !ctrl_bare;
    end
    res_next.run_last    = (work_cnt == (CNT_W+1)'(1));
    res_next.string_done = (work_cnt == (CNT_W+1)'(1)) && str_end;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      result <= res_next;
    end
  end

  // checks
  `DTOK_ASSERT_NOW(a_rem_in_window, clk, rst, 1'b1, rem <= held,
    "bytes to release exceed the window fill")
  `DTOK_ASSERT_NOW(a_idle_window, clk, rst, (rem == '0) && (ctrl_cnt == '0),
    held < CNT_W'(DELIM_MAX), "full window left behind after a transaction")
  `DTOK_ASSERT_NOW(a_bare_alone, clk, rst, ctrl_bare && (ctrl_cnt != '0),
    (rem == '0) && (ctrl_cnt == 2'd1), "bare string end mixed with other results")
  `DTOK_ASSERT_NXT(a_end_clears, clk, rst, accept && item.string_end,
    (held == rem) && !tok_ne && !esc_pend, "string end left held state")

endmodule
